@@ src/fhp_pkg.sv @@
// ----------------------------------------------------------------------------
// fhp_pkg: shared types and helpers for the fixed Huffman token packer
// Token kinds, the queue entry format and the code-building functions.
// ----------------------------------------------------------------------------
`default_nettype none

package fhp_pkg;

    // Token kinds on the input channel
    typedef enum logic [1:0] {
        MODE_LIT   = 2'd0,
        MODE_MATCH = 2'd1,
        MODE_END   = 2'd2,
        MODE_NONE  = 2'd3
    } fhp_mode_t;

    // Longest bit string of one token: header 2 + length code 8 + length
    // extra 5 + distance code 5 + distance extra 13.
    localparam int TOK_BITS = 33;
    localparam int TOK_CNT_W = $clog2(TOK_BITS + 1);
    localparam int HW_BITS = 16;
    // Packer window: up to 15 leftover bits ahead of one token
    localparam int WIN_BITS = TOK_BITS + HW_BITS - 1;
    localparam int WIN_CNT_W = $clog2(WIN_BITS + 1);
    localparam int QDEPTH = 2;

    localparam logic [15:0] CAP_RESET = 16'hffff;

    // One coded token, bits left-justified (first bit at the MSB)
    typedef struct packed {
        logic [TOK_BITS-1:0]  bits;
        logic [TOK_CNT_W-1:0] nbits;
        logic                 flush;
    } fhp_tok_t;

    // Fixed literal/length code, natural bit order: {length, code}
    function automatic logic [12:0] fhp_litlen(input logic [8:0] sym);
        logic [8:0] code;
        logic [3:0] len;
        if (sym < 9'd144) begin
            code = 9'h030 + sym;
            len  = 4'd8;
        end else if (sym < 9'd256) begin
            code = 9'h190 + (sym - 9'd144);
            len  = 4'd9;
        end else if (sym < 9'd280) begin
            code = sym - 9'd256;
            len  = 4'd7;
        end else begin
            code = 9'h0c0 + (sym - 9'd280);
            len  = 4'd8;
        end
        return {len, code};
    endfunction

    // Index of the highest set bit (0 when the value is 0)
    function automatic logic [3:0] fhp_msb15(input logic [14:0] v);
        logic [3:0] pos;
        pos = 4'd0;
        for (int i = 0; i < 15; i++) begin
            if (v[i]) begin
                pos = 4'(i);
            end
        end
        return pos;
    endfunction

    // Append n low bits of val to a right-justified bit string
    function automatic logic [TOK_BITS-1:0] fhp_append(
        input logic [TOK_BITS-1:0]  acc,
        input logic [TOK_BITS-1:0]  val,
        input logic [TOK_CNT_W-1:0] n
    );
        return (acc << n) | val;
    endfunction

endpackage

`default_nettype wire

@@ src/fhp_front.sv @@
// ----------------------------------------------------------------------------
// fhp_front: token classifier and encoder
// Accepts tokens, builds the full bit string of each and pushes it to the queue; unused-mode tokens are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module fhp_front (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic [1:0]       s_mode,
    input  wire logic [7:0]       s_literal_byte,
    input  wire logic [8:0]       s_match_length,
    input  wire logic [15:0]      s_match_distance,
    input  wire logic             q_full,
    output logic                  q_push,
    output fhp_pkg::fhp_tok_t     q_din
);
    import fhp_pkg::*;

    logic header_pending_reg;
    logic header_pending_next;
    logic accept;

    fhp_mode_t mode;

    logic [12:0] ll;
    logic [8:0]  lsym;
    logic [8:0]  len_c;
    logic [7:0]  lx;
    logic [3:0]  lp;
    logic [3:0]  lp_m1;
    logic [7:0]  ltop;
    logic [2:0]  le_n;
    logic [4:0]  le_v;
    logic [15:0] dist_c;
    logic [14:0] dx;
    logic [3:0]  dp;
    logic [4:0]  dcode;
    logic [3:0]  de_n;
    logic [12:0] de_v;
    logic [14:0] dtop;

    logic [TOK_BITS-1:0]  acc;
    logic [TOK_CNT_W-1:0] cnt;

    assign mode    = fhp_mode_t'(s_mode);
    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign q_push  = accept && (mode != MODE_NONE);

    // Length symbol and extra bits
    always_comb begin
        if (s_match_length < 9'd3) begin
            len_c = 9'd3;
        end else if (s_match_length > 9'd258) begin
            len_c = 9'd258;
        end else begin
            len_c = s_match_length;
        end
        lx    = 8'(len_c - 9'd3);
        lp    = fhp_msb15({7'd0, lx});
        lp_m1 = lp - 4'd1;
        ltop  = lx >> (lp - 4'd2);
        if (len_c == 9'd258) begin
            lsym = 9'd285;
            le_n = 3'd0;
            le_v = 5'd0;
        end else if (lx < 8'd8) begin
            lsym = 9'd257 + {1'b0, lx};
            le_n = 3'd0;
            le_v = 5'd0;
        end else begin
            lsym = 9'd257 + {3'd0, lp_m1, 2'b00} + {7'd0, ltop[1:0]};
            le_n = 3'(lp - 4'd2);
            le_v = 5'(lx & ((8'd1 << (lp - 4'd2)) - 8'd1));
        end
    end

    // Distance code and extra bits
    always_comb begin
        if (s_match_distance == 16'd0) begin
            dist_c = 16'd1;
        end else if (s_match_distance > 16'd32768) begin
            dist_c = 16'd32768;
        end else begin
            dist_c = s_match_distance;
        end
        dx   = 15'(dist_c - 16'd1);
        dp   = fhp_msb15(dx);
        dtop = dx >> (dp - 4'd1);
        if (dx < 15'd4) begin
            dcode = dx[4:0];
            de_n  = 4'd0;
            de_v  = 13'd0;
        end else begin
            dcode = {dp, 1'b0} + {4'd0, dtop[0]};
            de_n  = dp - 4'd1;
            de_v  = 13'(dx & ((15'd1 << (dp - 4'd1)) - 15'd1));
        end
    end

    // Bit string assembly
    always_comb begin
        acc   = '0;
        cnt   = '0;
        ll    = '0;
        if (header_pending_reg) begin
            acc = TOK_BITS'(2'b01);
            cnt = TOK_CNT_W'(2);
        end
        unique case (mode)
            MODE_LIT: begin
                ll  = fhp_litlen({1'b0, s_literal_byte});
                acc = fhp_append(acc, TOK_BITS'(ll[8:0]), TOK_CNT_W'(ll[12:9]));
                cnt = cnt + TOK_CNT_W'(ll[12:9]);
            end
            MODE_MATCH: begin
                ll  = fhp_litlen(lsym);
                acc = fhp_append(acc, TOK_BITS'(ll[8:0]), TOK_CNT_W'(ll[12:9]));
                cnt = cnt + TOK_CNT_W'(ll[12:9]);
                acc = fhp_append(acc, TOK_BITS'(le_v), TOK_CNT_W'(le_n));
                cnt = cnt + TOK_CNT_W'(le_n);
                acc = fhp_append(acc, TOK_BITS'(dcode), TOK_CNT_W'(5));
                cnt = cnt + TOK_CNT_W'(5);
                acc = fhp_append(acc, TOK_BITS'(de_v), TOK_CNT_W'(de_n));
                cnt = cnt + TOK_CNT_W'(de_n);
            end
            MODE_END: begin
                // end-of-block symbol is seven zero bits
                acc = fhp_append(acc, '0, TOK_CNT_W'(7));
                cnt = cnt + TOK_CNT_W'(7);
            end
            default: begin
                acc = '0;
                cnt = '0;
            end
        endcase
        q_din.bits  = acc << (TOK_CNT_W'(TOK_BITS) - cnt);
        q_din.nbits = cnt;
        q_din.flush = (mode == MODE_END);
    end

    always_comb begin
        header_pending_next = header_pending_reg;
        if (q_push) begin
            header_pending_next = (mode == MODE_END);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_pending_reg <= 1'b1;
        end else begin
            header_pending_reg <= header_pending_next;
        end
    end

endmodule

`default_nettype wire

@@ src/fhp_fifo.sv @@
// ----------------------------------------------------------------------------
// fhp_fifo: short token queue
// Decouples the encoder from the packer so each side stalls on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module fhp_fifo (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire fhp_pkg::fhp_tok_t din,
    input  wire logic              pop,
    output fhp_pkg::fhp_tok_t      dout,
    output logic                   full,
    output logic                   empty
);
    import fhp_pkg::*;

    localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CNT_W = $clog2(QDEPTH + 1);

    fhp_tok_t         mem [QDEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_next;

    assign full  = (count_reg == CNT_W'(QDEPTH));
    assign empty = (count_reg == '0);
    assign dout  = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

@@ src/fhp_back.sv @@
// ----------------------------------------------------------------------------
// fhp_back: bit packer and halfword emitter
// Merges token bits into the window, emits halfwords, flushes, tracks capacity.
// ----------------------------------------------------------------------------
`default_nettype none

module fhp_back (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire fhp_pkg::fhp_tok_t q_dout,
    input  wire logic              q_empty,
    output logic                   q_pop,
    input  wire logic              cfg_we,
    input  wire logic [15:0]       cfg_capacity,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [15:0]            m_halfword,
    output logic                   m_last_of_run,
    output logic                   m_overflow
);
    import fhp_pkg::*;

    logic [WIN_BITS-1:0]  win_reg,   win_next;
    logic [WIN_CNT_W-1:0] wcnt_reg,  wcnt_next;
    logic                 flush_reg, flush_next;
    logic [15:0]          cap_reg;
    logic [15:0]          hw_cnt_reg, hw_cnt_next;
    logic                 ovf_reg,    ovf_next;
    logic                 mv_reg,     mv_next;
    logic [15:0]          hw_reg,     hw_next;
    logic                 last_reg,   last_next;
    logic                 movf_reg,   movf_next;

    logic busy;
    logic emit;
    logic has_room;

    assign busy     = (wcnt_reg >= WIN_CNT_W'(HW_BITS)) || flush_reg;
    assign q_pop    = !busy && !q_empty;
    assign emit     = busy && (!mv_reg || m_ready);
    assign has_room = (hw_cnt_reg < cap_reg);

    assign m_valid       = mv_reg;
    assign m_halfword    = hw_reg;
    assign m_last_of_run = last_reg;
    assign m_overflow    = movf_reg;

    always_comb begin
        win_next    = win_reg;
        wcnt_next   = wcnt_reg;
        flush_next  = flush_reg;
        hw_cnt_next = hw_cnt_reg;
        ovf_next    = ovf_reg;
        mv_next     = mv_reg && !m_ready;
        hw_next     = hw_reg;
        last_next   = last_reg;
        movf_next   = movf_reg;

        if (q_pop) begin
            // leftover bits sit at the top, new bits go right behind them
            win_next   = win_reg
                       | ({q_dout.bits, (WIN_BITS - TOK_BITS)'(0)} >> wcnt_reg[3:0]);
            wcnt_next  = wcnt_reg + WIN_CNT_W'(q_dout.nbits);
            flush_next = q_dout.flush;
        end

        if (emit) begin
            mv_next = 1'b1;
            priority if (wcnt_reg >= WIN_CNT_W'(HW_BITS)) begin
                hw_next   = win_reg[WIN_BITS-1 -: HW_BITS];
                win_next  = win_reg << HW_BITS;
                wcnt_next = wcnt_reg - WIN_CNT_W'(HW_BITS);
                last_next = (wcnt_reg < WIN_CNT_W'(2 * HW_BITS)) && !flush_reg;
            end else if (wcnt_reg != '0) begin
                // pad the partial halfword with zeros
                hw_next   = win_reg[WIN_BITS-1 -: HW_BITS];
                win_next  = '0;
                wcnt_next = '0;
                last_next = 1'b0;
            end else begin
                // trailing all-zero halfword closes the block
                hw_next    = '0;
                flush_next = 1'b0;
                last_next  = 1'b1;
            end
            if (has_room) begin
                hw_cnt_next = hw_cnt_reg + 16'd1;
            end else begin
                ovf_next = 1'b1;
            end
            movf_next = ovf_reg || !has_room;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg    <= '0;
            wcnt_reg   <= '0;
            flush_reg  <= 1'b0;
            cap_reg    <= CAP_RESET;
            hw_cnt_reg <= '0;
            ovf_reg    <= 1'b0;
            mv_reg     <= 1'b0;
        end else begin
            win_reg    <= win_next;
            wcnt_reg   <= wcnt_next;
            flush_reg  <= flush_next;
            hw_cnt_reg <= hw_cnt_next;
            ovf_reg    <= ovf_next;
            mv_reg     <= mv_next;
            if (cfg_we) begin
                cap_reg <= cfg_capacity;
            end
        end
    end

    always_ff @(posedge aclk) begin
        hw_reg   <= hw_next;
        last_reg <= last_next;
        movf_reg <= movf_next;
    end

endmodule

`default_nettype wire

@@ src/fixed_huffman_token_packer.sv @@
// ----------------------------------------------------------------------------
// fixed_huffman_token_packer: fixed-Huffman block writer, MSB first
// LZ77 tokens in, 16-bit halfwords of a fixed-code block out.
// ----------------------------------------------------------------------------
//
//  channel   direction  ports                                    beat
//  s_*       in         mode, literal_byte, match_length, dist   one token
//  m_*       out        halfword, last_of_run, overflow          one halfword
//  cfg_*     in         cfg_data                                 capacity write
//
//  A token is taken per cycle while the two-entry queue has room. The packer
//  merges a token and yields each halfword in separate steps, taking a new
//  token only with under 16 bits held and no flush pending; a token yields up
//  to three halfwords. The front encodes in the accept cycle; a token then
//  crosses queue, window and output register. m_ready low stalls only the
//  packer; the front keeps filling the queue until it is full.
//  Reset (aresetn low, synchronous) clears the bit window, the halfword count
//  and the overflow flag, sets the header flag (next token gets the block type)
//  and sets capacity to 65535.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_huffman_token_packer (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // token input
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_mode,
    input  wire logic [7:0]  s_literal_byte,
    input  wire logic [8:0]  s_match_length,
    input  wire logic [15:0] s_match_distance,
    // halfword output
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [15:0]      m_halfword,
    output logic             m_last_of_run,
    output logic             m_overflow,
    // capacity register write
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data
);
    import fhp_pkg::*;

    fhp_tok_t q_din;
    fhp_tok_t q_dout;
    logic     q_push;
    logic     q_pop;
    logic     q_full;
    logic     q_empty;

    // Register writes are always taken
    assign cfg_ready = 1'b1;

    // Front: classify the token, build its complete code string
    fhp_front u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_mode           (s_mode),
        .s_literal_byte   (s_literal_byte),
        .s_match_length   (s_match_length),
        .s_match_distance (s_match_distance),
        .q_full           (q_full),
        .q_push           (q_push),
        .q_din            (q_din)
    );

    // Token queue between encoder and packer
    fhp_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .din     (q_din),
        .pop     (q_pop),
        .dout    (q_dout),
        .full    (q_full),
        .empty   (q_empty)
    );

    // Back: pack bits, emit halfwords, flush on end of block, track capacity
    fhp_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_dout        (q_dout),
        .q_empty       (q_empty),
        .q_pop         (q_pop),
        .cfg_we        (cfg_valid && cfg_ready),
        .cfg_capacity  (cfg_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_halfword    (m_halfword),
        .m_last_of_run (m_last_of_run),
        .m_overflow    (m_overflow)
    );

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: fixed Huffman token packer check
// Drives literal, match and end tokens, with idle cycles on both channels.
// A scoreboard class rebuilds the MSB-first bit stream and checks each
// halfword. The capacity register is swept from its top value down to zero.
// ----------------------------------------------------------------------------

import fhp_pkg::*;

typedef struct packed {
    logic [15:0] halfword;
    logic        last;
    logic        ovf;
} hw_beat_t;

// Bit stream predictor plus the queue of halfwords still owed by the block
class halfword_scoreboard;
    int unsigned capacity;
    int unsigned acc;
    int unsigned nbits;
    int unsigned written;
    bit          header_due;
    bit          ovf_sticky;
    int unsigned tok_beats;
    int unsigned fails;
    hw_beat_t    owed_q[$];

    function void clear();
        capacity   = 65535;
        acc        = 0;
        nbits      = 0;
        written    = 0;
        header_due = 1'b1;
        ovf_sticky = 1'b0;
        fails      = 0;
        owed_q.delete();
    endfunction

    function void set_capacity(logic [15:0] v);
        capacity = v;
    endfunction

    function int unsigned top_bit(int unsigned v);
        int unsigned pos;
        pos = 0;
        for (int i = 0; i < 32; i++) begin
            if (v[i]) begin
                pos = i;
            end
        end
        return pos;
    endfunction

    // Shift n low bits of v in behind the pending ones; peel off full halfwords
    function void push_bits(int unsigned v, int unsigned n);
        hw_beat_t b;
        if (n == 0) begin
            return;
        end
        acc   = (acc << n) | (v & ((32'd1 << n) - 1));
        nbits = nbits + n;
        while (nbits >= 16) begin
            b.halfword = 16'((acc >> (nbits - 16)) & 32'hffff);
            if (written < capacity) begin
                written++;
            end else begin
                ovf_sticky = 1'b1;
            end
            b.last = 1'b0;
            b.ovf  = ovf_sticky;
            owed_q.push_back(b);
            tok_beats++;
            nbits = nbits - 16;
        end
        acc = acc & ((32'd1 << nbits) - 1);
    endfunction

    function void push_litlen(int unsigned sym);
        if (sym < 144) begin
            push_bits(32'h30 + sym, 8);
        end else if (sym < 256) begin
            push_bits(32'h190 + sym - 144, 9);
        end else if (sym < 280) begin
            push_bits(sym - 256, 7);
        end else begin
            push_bits(32'hc0 + sym - 280, 8);
        end
    endfunction

    function void note_token(fhp_mode_t md, logic [7:0] lit, logic [8:0] mlen,
                             logic [15:0] mdist);
        int unsigned len_v, dist_v, v, e, idx, base;
        if (md == MODE_NONE) begin
            return;
        end
        tok_beats = 0;
        if (header_due) begin
            push_bits(1, 2);
            header_due = 1'b0;
        end
        case (md)
            MODE_LIT: begin
                push_litlen(lit);
            end
            MODE_MATCH: begin
                len_v  = (mlen < 3) ? 3 : ((mlen > 258) ? 258 : mlen);
                dist_v = (mdist < 1) ? 1 : ((mdist > 32768) ? 32768 : mdist);
                // length symbol: lengths 3..10 are direct, 258 has its own code,
                // the rest fall in groups of four per extra-bit count
                if (len_v == 258) begin
                    push_litlen(285);
                end else if (len_v < 11) begin
                    push_litlen(257 + len_v - 3);
                end else begin
                    v    = len_v - 3;
                    e    = top_bit(v) - 2;
                    idx  = 4 * e + 4 + ((v >> e) & 3);
                    base = ((4 | ((v >> e) & 3)) << e) + 3;
                    push_litlen(257 + idx);
                    push_bits(len_v - base, e);
                end
                // distance symbol: two per extra-bit count above the first four
                v = dist_v - 1;
                if (v < 4) begin
                    push_bits(v, 5);
                end else begin
                    e    = top_bit(v) - 1;
                    idx  = 2 * e + 2 + ((v >> e) & 1);
                    base = ((2 | ((v >> e) & 1)) << e) + 1;
                    push_bits(idx, 5);
                    push_bits(dist_v - base, e);
                end
            end
            default: begin
                push_litlen(256);
                if (nbits != 0) begin
                    push_bits(0, 16 - nbits);
                end
                push_bits(0, 16);
                header_due = 1'b1;
            end
        endcase
        if (tok_beats > 0) begin
            owed_q[owed_q.size() - 1].last = 1'b1;
        end
    endfunction

    function void check_halfword(logic [15:0] hw, logic last, logic ovf);
        hw_beat_t exp_b;
        if (owed_q.size() == 0) begin
            $error("halfword 0x%04h with no expectation", hw);
            fails++;
            return;
        end
        exp_b = owed_q.pop_front();
        if (hw !== exp_b.halfword) begin
            $error("halfword: expected 0x%04h, got 0x%04h", exp_b.halfword, hw);
            fails++;
        end
        if (last !== exp_b.last) begin
            $error("last_of_run: expected %0b, got %0b", exp_b.last, last);
            fails++;
        end
        if (ovf !== exp_b.ovf) begin
            $error("overflow: expected %0b, got %0b", exp_b.ovf, ovf);
            fails++;
        end
    endfunction
endclass

module testbench;

    // Extra wait after the last owed halfword, for whatever the two-deep queue
    // and the packer may still hold.
    localparam int DRAIN_CYCLES = 24;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int PHASE_TOKENS = 60;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_mode;
    logic [7:0]  s_literal_byte;
    logic [8:0]  s_match_length;
    logic [15:0] s_match_distance;
    logic        m_valid;
    logic        m_ready;
    logic [15:0] m_halfword;
    logic        m_last_of_run;
    logic        m_overflow;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;

    halfword_scoreboard sb;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned cycle_count;

    fixed_huffman_token_packer i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_mode           (s_mode),
        .s_literal_byte   (s_literal_byte),
        .s_match_length   (s_match_length),
        .s_match_distance (s_match_distance),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_halfword       (m_halfword),
        .m_last_of_run    (m_last_of_run),
        .m_overflow       (m_overflow),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Watchdog: a hung handshake ends the run here
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Receiver: ready is set at the falling edge, beats taken at the rising edge
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            m_ready = ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_halfword(m_halfword, m_last_of_run, m_overflow);
        end
    end

    // One token beat. Valid stays up from the previous beat unless an idle
    // cycle is drawn, so back-to-back beats never toggle valid.
    task automatic send_token(input fhp_mode_t md, input logic [7:0] lit,
                              input logic [8:0] mlen, input logic [15:0] mdist);
        @(negedge aclk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid          = 1'b1;
        s_mode           = md;
        s_literal_byte   = lit;
        s_match_length   = mlen;
        s_match_distance = mdist;
        do @(posedge aclk); while (!s_ready);
        sb.note_token(md, lit, mlen, mdist);
    endtask

    // Drop valid, wait out every owed halfword plus the packer's tail
    task automatic drain();
        @(negedge aclk);
        s_valid = 1'b0;
        while (sb.owed_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_capacity(input logic [15:0] v);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_data  = v;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_capacity(v);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Random match: mostly legal lengths and distances, spread over all the
    // extra-bit groups, with a share of clamped out-of-range values
    task automatic send_match();
        logic [8:0]  mlen;
        logic [15:0] mdist;
        int unsigned k;
        case ($urandom_range(0, 9))
            0:       mlen = $urandom_range(0, 1) ? 9'($urandom_range(0, 2))
                                                 : 9'($urandom_range(259, 511));
            1, 2, 3: mlen = 9'($urandom_range(3, 10));
            default: mlen = 9'($urandom_range(3, 258));
        endcase
        if ($urandom_range(0, 9) == 0) begin
            mdist = $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(32768, 65535));
        end else begin
            k     = $urandom_range(0, 14);
            mdist = 16'($urandom_range(1 << k, (2 << k) - 1));
        end
        send_token(MODE_MATCH, 8'($urandom), mlen, mdist);
    endtask

    // Random blocks of literals and matches closed by an end token. Some
    // blocks are empty, some run on without an end; stray unused-mode beats
    // are thrown in and not counted.
    task automatic run_blocks(input int unsigned n_tokens);
        int unsigned sent;
        int unsigned blk_len;
        sent = 0;
        while (sent < n_tokens) begin
            blk_len = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 12);
            for (int unsigned i = 0; i < blk_len; i++) begin
                if ($urandom_range(0, 19) == 0) begin
                    send_token(MODE_NONE, 8'($urandom), 9'($urandom), 16'($urandom));
                end
                if ($urandom_range(0, 99) < 55) begin
                    send_token(MODE_LIT, 8'($urandom), 9'($urandom), 16'($urandom));
                end else begin
                    send_match();
                end
                sent++;
            end
            if ($urandom_range(0, 9) != 0) begin
                send_token(MODE_END, 8'($urandom), 9'($urandom), 16'($urandom));
                sent++;
            end
        end
    endtask

    initial begin
        sb = new();
        sb.clear();
        aresetn          = 1'b0;
        s_valid          = 1'b0;
        s_mode           = MODE_LIT;
        s_literal_byte   = '0;
        s_match_length   = '0;
        s_match_distance = '0;
        cfg_valid        = 1'b0;
        cfg_data         = '0;
        send_idle_pct    = 0;
        recv_idle_pct    = 0;
        cycle_count      = 0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: code-length boundaries of literals, length and distance
        // extremes, clamping, unused mode and back-to-back ends
        send_idle_pct = 20;
        recv_idle_pct = 20;
        write_capacity(16'hffff);
        send_token(MODE_LIT,   8'd0,   9'd0,   16'd0);
        send_token(MODE_LIT,   8'd143, 9'd0,   16'd0);
        send_token(MODE_LIT,   8'd144, 9'd511, 16'hffff);
        send_token(MODE_LIT,   8'd255, 9'd511, 16'hffff);
        send_token(MODE_MATCH, 8'd0,   9'd3,   16'd1);
        send_token(MODE_MATCH, 8'hff,  9'd258, 16'd32768);
        send_token(MODE_MATCH, 8'd0,   9'd10,  16'd4);
        send_token(MODE_MATCH, 8'd0,   9'd11,  16'd5);
        send_token(MODE_MATCH, 8'd0,   9'd257, 16'd24577);
        send_token(MODE_MATCH, 8'd0,   9'd2,   16'd0);
        send_token(MODE_MATCH, 8'd0,   9'd0,   16'hffff);
        send_token(MODE_MATCH, 8'd0,   9'd511, 16'd32769);
        send_token(MODE_MATCH, 8'd0,   9'd259, 16'd2);
        send_token(MODE_NONE,  8'hff,  9'd511, 16'hffff);
        send_token(MODE_END,   8'd0,   9'd0,   16'd0);
        send_token(MODE_END,   8'hff,  9'd511, 16'hffff);
        send_token(MODE_NONE,  8'd0,   9'd0,   16'd0);
        send_token(MODE_MATCH, 8'd0,   9'd114, 16'd24576);
        send_token(MODE_LIT,   8'd97,  9'd0,   16'd0);
        send_token(MODE_END,   8'd0,   9'd0,   16'd0);
        drain();

        // Sender mostly busy, receiver mostly stalled; top capacity
        send_idle_pct = 36;
        recv_idle_pct = 73;
        write_capacity(16'hffff);
        run_blocks(PHASE_TOKENS);
        drain();

        // Roles swapped; capacity well above what the run reaches
        send_idle_pct = 73;
        recv_idle_pct = 36;
        write_capacity(16'($urandom_range(sb.written + 500, 65534)));
        run_blocks(PHASE_TOKENS);
        drain();

        // No idling; capacity runs out partway and overflow latches
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_capacity(16'(sb.written + $urandom_range(10, 40)));
        run_blocks(PHASE_TOKENS);
        drain();

        // Capacity dropped below the count already written
        write_capacity(16'd0);
        run_blocks(15);
        drain();

        if (sb.fails == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
